>>> rtl/lrn_cross_channel_scale_assert.svh
// assertion macros for the cross-channel scale block
`ifndef LRN_CROSS_CHANNEL_SCALE_ASSERT_SVH
`define LRN_CROSS_CHANNEL_SCALE_ASSERT_SVH

// checked outside reset
`define LCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define LCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/lcs_pkg.sv
// shared constants and types of the cross-channel scale block
`timescale 1ns / 1ps
`default_nettype none

package lcs_pkg;

  localparam int unsigned MAX_WINDOW   = 16;
  localparam int unsigned MAX_CHANNELS = 1024;

  localparam int unsigned RING_AW  = $clog2(MAX_WINDOW);
  localparam int unsigned CNT_W    = $clog2(MAX_CHANNELS + MAX_WINDOW);
  localparam int unsigned SIZE_W   = 5;
  localparam int unsigned POST_W   = $clog2(MAX_WINDOW / 2 + 1);
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned SQ_W     = 31;
  localparam int unsigned SUM_W    = 35;
  localparam int unsigned SCALE_W  = 32;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned ALPHA_W  = 24;
  localparam int unsigned BIAS_W   = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_TDATA_W = ((SCALE_W + IDX_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_K      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 2'd2;

  localparam logic [SIZE_W-1:0]  RST_WINDOW_SIZE = 5'd5;
  localparam logic [BIAS_W-1:0]  RST_BIAS_K      = 32'd65536;
  localparam logic [ALPHA_W-1:0] RST_ALPHA       = 24'd336;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [IDX_W-1:0] index;
    logic             done;
    logic             too_long;
  } emit_req_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } scale_stat_t;

endpackage

`default_nettype wire

>>> rtl/lrn_cross_channel_scale.sv
// top level: cross-channel normalization scale with config registers
// an item that gives a result passes accept, ring read, sum update, launch and advance;
// the end of a column adds flush and finish steps plus ring read, sum update, launch and advance per flushed channel
// after its launch a result passes the multiply, round and bias/saturate registers of the pipe
// a launch waits until the pipe and the output register are empty
// reset clears control, count, sum and config; the square ring has no reset
`timescale 1ns / 1ps
`default_nettype none

module lrn_cross_channel_scale import lcs_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [SAMPLE_W-1:0]    s_axis_tdata_i,   // sample
  input  wire logic                   s_axis_tlast_i,
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata_o,   // scale_value, channel_index, zero pad
  output logic                        m_axis_tlast_o,
  output logic                        m_axis_tuser_o    // too_long
);

  logic [SIZE_W-1:0]  window_size_q;
  logic [BIAS_W-1:0]  bias_k_q;
  logic [ALPHA_W-1:0] alpha_q;

  logic               rd_en, wr_en;
  logic [RING_AW-1:0] rd_addr, wr_addr;
  logic [SQ_W-1:0]    rd_data, wr_data;
  scale_stat_t        stat;
  logic               start;
  emit_req_t          req;
  logic [SCALE_W-1:0] scale;
  logic [IDX_W-1:0]   index;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= RST_WINDOW_SIZE;
      bias_k_q      <= RST_BIAS_K;
      alpha_q       <= RST_ALPHA;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_WINDOW_SIZE: window_size_q <= cfg_data_i[SIZE_W-1:0];
        REG_BIAS_K:      bias_k_q      <= cfg_data_i[BIAS_W-1:0];
        REG_ALPHA:       alpha_q       <= cfg_data_i[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  lcs_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .window_size_i(window_size_q),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .sample_i     ($signed(s_axis_tdata_i)),
    .last_i       (s_axis_tlast_i),
    .rd_en_o      (rd_en),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data),
    .wr_en_o      (wr_en),
    .wr_addr_o    (wr_addr),
    .wr_data_o    (wr_data),
    .stat_i       (stat),
    .start_o      (start),
    .req_o        (req)
  );

  lcs_ring_mem u_ring (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  lcs_scale_pipe u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .req_i     (req),
    .alpha_i   (alpha_q),
    .bias_i    (bias_k_q),
    .stat_o    (stat),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .scale_o   (scale),
    .index_o   (index),
    .done_o    (m_axis_tlast_o),
    .too_long_o(m_axis_tuser_o)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_W - SCALE_W - IDX_W)'(0), index, scale};

endmodule

`default_nettype wire

>>> rtl/lcs_ring_mem.sv
// ring of recent squares, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module lcs_ring_mem import lcs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               wr_en_i,
  input  wire logic [RING_AW-1:0] wr_addr_i,
  input  wire logic [SQ_W-1:0]    wr_data_i,
  input  wire logic               rd_en_i,
  input  wire logic [RING_AW-1:0] rd_addr_i,
  output logic      [SQ_W-1:0]    rd_data_o
);

  logic [SQ_W-1:0] mem_q [MAX_WINDOW];
  logic [SQ_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

>>> rtl/lcs_scale_pipe.sv
// scale pipeline: multiply by alpha, round, add bias, saturate, output register
`timescale 1ns / 1ps
`default_nettype none

module lcs_scale_pipe import lcs_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire emit_req_t          req_i,
  input  wire logic [ALPHA_W-1:0] alpha_i,
  input  wire logic [BIAS_W-1:0]  bias_i,
  output scale_stat_t             stat_o,
  output logic                    m_valid_o,
  input  wire logic               m_ready_i,
  output logic      [SCALE_W-1:0] scale_o,
  output logic      [IDX_W-1:0]   index_o,
  output logic                    done_o,
  output logic                    too_long_o
);

  localparam int unsigned LO_W   = 32;
  localparam int unsigned HI_W   = SUM_W - LO_W;
  localparam int unsigned LO_P_W = LO_W + ALPHA_W;
  localparam int unsigned HI_P_W = HI_W + ALPHA_W;
  localparam logic [LO_P_W:0] ROUND = (LO_P_W + 1)'(1) << (ALPHA_W - 1);

  logic              v1_q, v2_q, out_v_q;
  logic [LO_P_W-1:0] lo_q;
  logic [HI_P_W-1:0] hi_q;
  logic [SUM_W-1:0]  base_d, base_q;
  logic [LO_P_W:0]   lo_rnd;
  logic [SUM_W:0]    total;
  logic [SCALE_W-1:0] sat_d, scale_q;
  logic [IDX_W-1:0]  idx1_q, idx2_q, idx_out_q;
  logic              done1_q, done2_q, done_out_q;
  logic              tl1_q, tl2_q, tl_out_q;

  always_comb begin
    lo_rnd = {1'b0, lo_q} + ROUND;
    base_d = SUM_W'(lo_rnd >> ALPHA_W) + (SUM_W'(hi_q) << (LO_W - ALPHA_W));
    total  = {1'b0, base_q} + (SUM_W + 1)'(bias_i);
    sat_d  = (|total[SUM_W:SCALE_W]) ? '1 : total[SCALE_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      v1_q <= start_i;
      v2_q <= v1_q;
      if (v2_q) begin
        out_v_q <= 1'b1;
      end else if (m_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lo_q    <= LO_P_W'(req_i.sum[LO_W-1:0] * alpha_i);
      hi_q    <= HI_P_W'(req_i.sum[SUM_W-1:LO_W] * alpha_i);
      idx1_q  <= req_i.index;
      done1_q <= req_i.done;
      tl1_q   <= req_i.too_long;
    end
    if (v1_q) begin
      base_q  <= base_d;
      idx2_q  <= idx1_q;
      done2_q <= done1_q;
      tl2_q   <= tl1_q;
    end
    if (v2_q) begin
      scale_q    <= sat_d;
      idx_out_q  <= idx2_q;
      done_out_q <= done2_q;
      tl_out_q   <= tl2_q;
    end
  end

  assign stat_o.busy     = v1_q | v2_q;
  assign stat_o.out_full = out_v_q;
  assign m_valid_o  = out_v_q;
  assign scale_o    = scale_q;
  assign index_o    = idx_out_q;
  assign done_o     = done_out_q;
  assign too_long_o = tl_out_q;

endmodule

`default_nettype wire

>>> rtl/lcs_ctrl.sv
// sequencer: running window sum, channel count, flush at end of column
`timescale 1ns / 1ps
`default_nettype none

module lcs_ctrl import lcs_pkg::*; (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic        [SIZE_W-1:0]   window_size_i,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       last_i,
  output logic                            rd_en_o,
  output logic             [RING_AW-1:0]  rd_addr_o,
  input  wire logic        [SQ_W-1:0]     rd_data_i,
  output logic                            wr_en_o,
  output logic             [RING_AW-1:0]  wr_addr_o,
  output logic             [SQ_W-1:0]     wr_data_o,
  input  wire scale_stat_t                stat_i,
  output logic                            start_o,
  output emit_req_t                       req_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_UPD  = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_NEXT = 3'd4;
  localparam logic [2:0] ST_FLS  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] h_q, h_d, fend_q, fend_d, chans_q, chans_d, count_q, count_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             ovf_q, ovf_d, last_q, last_d, main_q, main_d;
  logic             emitted_q, emitted_d, fb_q, fb_d;
  logic [SQ_W-1:0]  sq_q, sq_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             done_q, done_d;

  logic [SIZE_W-1:0]         sz;
  logic [POST_W-1:0]         post;
  logic signed [2*SAMPLE_W-1:0] prod_s;
  logic                      h_ge_sz, h_ge_post, launch;

  always_comb begin
    if (window_size_i == '0) begin
      sz = SIZE_W'(1);
    end else if (window_size_i > SIZE_W'(MAX_WINDOW)) begin
      sz = SIZE_W'(MAX_WINDOW);
    end else begin
      sz = window_size_i;
    end
    post      = POST_W'(sz >> 1);
    h_ge_sz   = h_q >= CNT_W'(sz);
    h_ge_post = h_q >= CNT_W'(post);
    prod_s    = sample_i * sample_i;
    launch    = !stat_i.busy && !stat_i.out_full;
  end

  always_comb begin
    state_d   = state_q;
    h_d       = h_q;
    fend_d    = fend_q;
    chans_d   = chans_q;
    count_d   = count_q;
    sum_d     = sum_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    main_d    = main_q;
    emitted_d = emitted_q;
    fb_d      = fb_q;
    sq_d      = sq_q;
    idx_d     = idx_q;
    done_d    = done_q;
    in_ready_o = 1'b0;
    rd_en_o   = 1'b0;
    rd_addr_o = RING_AW'(h_q - CNT_W'(sz));
    wr_en_o   = 1'b0;
    wr_addr_o = h_q[RING_AW-1:0];
    wr_data_o = sq_q;
    start_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          sq_d      = prod_s[SQ_W-1:0];
          last_d    = last_i;
          emitted_d = 1'b0;
          fb_d      = 1'b0;
          if (count_q < CNT_W'(MAX_CHANNELS)) begin
            h_d     = count_q;
            main_d  = 1'b1;
            state_d = ST_RD;
          end else begin
            ovf_d   = 1'b1;
            state_d = last_i ? ST_FLS : ST_IDLE;
          end
        end
      end
      ST_RD: begin
        rd_en_o = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        sum_d = sum_q + (main_q ? SUM_W'(sq_q) : '0) - (h_ge_sz ? SUM_W'(rd_data_i) : '0);
        wr_en_o = main_q;
        idx_d   = IDX_W'(h_q - CNT_W'(post));
        done_d  = main_q ? (last_q && (post == '0)) : (h_q == fend_q);
        state_d = h_ge_post ? ST_EMIT : ST_NEXT;
      end
      ST_EMIT: begin
        if (launch) begin
          start_o   = 1'b1;
          emitted_d = 1'b1;
          state_d   = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (fb_q) begin
          count_d = '0;
          sum_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else if (main_q) begin
          count_d = h_q + CNT_W'(1);
          state_d = last_q ? ST_FLS : ST_IDLE;
        end else if (h_q == fend_q) begin
          state_d = ST_FIN;
        end else begin
          h_d     = h_q + CNT_W'(1);
          state_d = ST_RD;
        end
      end
      ST_FLS: begin
        chans_d = count_q;
        if (post == '0) begin
          state_d = ST_FIN;
        end else begin
          h_d     = count_q;
          fend_d  = count_q + CNT_W'(post) - CNT_W'(1);
          main_d  = 1'b0;
          state_d = ST_RD;
        end
      end
      ST_FIN: begin
        if (!emitted_q && ovf_q) begin
          idx_d   = IDX_W'(chans_q - CNT_W'(1));
          done_d  = 1'b1;
          fb_d    = 1'b1;
          state_d = ST_EMIT;
        end else begin
          count_d = '0;
          sum_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      h_q       <= '0;
      fend_q    <= '0;
      chans_q   <= '0;
      count_q   <= '0;
      sum_q     <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      main_q    <= 1'b0;
      emitted_q <= 1'b0;
      fb_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      h_q       <= h_d;
      fend_q    <= fend_d;
      chans_q   <= chans_d;
      count_q   <= count_d;
      sum_q     <= sum_d;
      ovf_q     <= ovf_d;
      last_q    <= last_d;
      main_q    <= main_d;
      emitted_q <= emitted_d;
      fb_q      <= fb_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q   <= sq_d;
    idx_q  <= idx_d;
    done_q <= done_d;
  end

  assign req_o.sum      = sum_q;
  assign req_o.index    = idx_q;
  assign req_o.done     = done_q;
  assign req_o.too_long = ovf_q;

endmodule

`default_nettype wire

>>> rtl/lcs_checker.sv
// port-level checks of the cross-channel scale block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "lrn_cross_channel_scale_assert.svh"

module lcs_checker import lcs_pkg::*; (
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   cfg_ready_o,
  input wire logic                   s_axis_tvalid_i,
  input wire logic                   s_axis_tready_o,
  input wire logic                   s_axis_tlast_i,
  input wire logic                   m_axis_tvalid_o,
  input wire logic                   m_axis_tready_i,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input wire logic                   m_axis_tlast_o,
  input wire logic                   m_axis_tuser_o
);

  `LCS_ASSERT(out_hold_a, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o), "result changed while stalled")
  `LCS_ASSERT(last_flush_a, s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> !s_axis_tready_o, "item taken during column flush")
  `LCS_ASSERT(cfg_open_a, !s_axis_tready_o |-> cfg_ready_o, "config port closed while busy")
  `LCS_ASSERT_ALWAYS(rst_quiet_a, !rst_ni |-> !m_axis_tvalid_o, "result shown during reset")

endmodule

bind lrn_cross_channel_scale lcs_checker u_lcs_checker (.*);

`default_nettype wire

>>> tb/lrn_cross_channel_scale_tb.sv
// testbench for the cross-channel scale block: directed and random columns checked against an inline scale model
`timescale 1ns / 1ps

module lrn_cross_channel_scale_tb;
  import lcs_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int QUIET_CYCLES = 64;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 800000;

  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [IDX_W-1:0]   chan;
    logic               done;
    logic               too_long;
  } scale_item_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   s_valid   = 1'b0;
  logic                   s_ready;
  logic [SAMPLE_W-1:0]    s_data    = '0;
  logic                   s_last    = 1'b0;
  logic                   m_valid;
  logic                   m_ready   = 1'b0;
  logic [OUT_TDATA_W-1:0] m_data;
  logic                   m_last;
  logic                   m_user;

  // model state and register copies
  logic [SIZE_W-1:0]  cur_wsize = RST_WINDOW_SIZE;
  logic [BIAS_W-1:0]  cur_bias  = RST_BIAS_K;
  logic [ALPHA_W-1:0] cur_alpha = RST_ALPHA;
  logic [SQ_W-1:0]    sq_hist [MAX_WINDOW];
  logic [SUM_W-1:0]   sum_sq    = '0;
  int                 chan_cnt  = 0;
  logic               over_flag = 1'b0;
  scale_item_t        due_scales [$];

  int err_cnt      = 0;
  bit tx_idle_en   = 1'b1;
  bit rx_idle_en   = 1'b1;
  int holds_asked  = 0;
  int holds_served = 0;
  int hold_left    = 0;
  int stall_left   = 0;

  lrn_cross_channel_scale u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tlast_o  (m_last),
    .m_axis_tuser_o  (m_user)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void retire_square(input int head, input int sz);
    if (head >= sz) sum_sq = sum_sq - sq_hist[(head - sz) % MAX_WINDOW];
  endfunction

  function automatic void queue_scale(input int chan, input logic done);
    scale_item_t e;
    logic [63:0] prod;
    logic [63:0] v;
    prod = 64'(sum_sq) * 64'(cur_alpha);
    v = ((prod + 64'd8388608) >> 24) + 64'(cur_bias);
    e.scale    = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    e.chan     = chan[IDX_W-1:0];
    e.done     = done;
    e.too_long = over_flag;
    due_scales.push_back(e);
  endfunction

  function automatic void predict_scales(input logic [SAMPLE_W-1:0] raw, input logic last);
    int x, sz, post, n, chans, h;
    logic [SQ_W-1:0] sq;
    x  = int'($signed(raw));
    sq = SQ_W'(x * x);
    if (cur_wsize == 0) sz = 1;
    else if (cur_wsize > MAX_WINDOW) sz = MAX_WINDOW;
    else sz = int'(cur_wsize);
    post = sz - (sz - 1) / 2 - 1;
    n = 0;
    if (chan_cnt < MAX_CHANNELS) begin
      sum_sq = sum_sq + sq;
      retire_square(chan_cnt, sz);
      sq_hist[chan_cnt % MAX_WINDOW] = sq;
      if (chan_cnt >= post) begin
        queue_scale(chan_cnt - post, last && post == 0);
        n++;
      end
      chan_cnt++;
    end else begin
      over_flag = 1'b1;
    end
    if (last) begin
      chans = chan_cnt;
      for (h = chans; h < chans + post; h++) begin
        retire_square(h, sz);
        if (h >= post) begin
          queue_scale(h - post, h == chans + post - 1);
          n++;
        end
      end
      // dropped end mark with nothing to flush repeats the last channel
      if (n == 0 && over_flag) queue_scale(chans - 1, 1'b1);
      chan_cnt  = 0;
      sum_sq    = '0;
      over_flag = 1'b0;
    end
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic last);
    int gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= value;
    s_last  <= last;
    do @(posedge clk); while (!s_ready);
    predict_scales(value, last);
  endtask

  task automatic send_column(input int len);
    int i;
    for (i = 0; i < len; i++) send_sample(pick_sample(), i == len - 1);
  endtask

  // lower the input and wait until every scale is out and the block is quiet
  task automatic settle();
    s_valid <= 1'b0;
    while (due_scales.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_WINDOW_SIZE: cur_wsize = data[SIZE_W-1:0];
      REG_BIAS_K:      cur_bias  = data[BIAS_W-1:0];
      REG_ALPHA:       cur_alpha = data[ALPHA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_window(input int size);
    logic [CFG_DATA_W-1:0] data;
    data = $urandom;
    data[SIZE_W-1:0] = SIZE_W'(size);
    write_reg(REG_WINDOW_SIZE, data);
  endtask

  task automatic test_reset_config();
    logic [SAMPLE_W-1:0] vals [6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
    int i;
    for (i = 0; i < 6; i++) send_sample(vals[i], i == 5);
    settle();
    // unmapped register must leave the others alone
    write_reg(REG_UNMAPPED, $urandom);
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h8000, 1'b1);
    settle();
  endtask

  task automatic test_window_sizes();
    int sizes [5] = '{0, 1, 2, 16, 31};
    int lens  [5] = '{1, 2, 3, 3, 1};
    int i, j;
    for (i = 0; i < 5; i++) begin
      write_window(sizes[i]);
      for (j = 0; j < lens[i]; j++)
        send_sample(j[0] ? 16'h8000 : 16'h7FFF, j == lens[i] - 1);
      settle();
    end
  endtask

  task automatic test_gain_extremes();
    write_window(16);
    write_reg(REG_BIAS_K, 32'hFFFF_FFFF);
    write_reg(REG_ALPHA, 32'h00FF_FFFF);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    settle();
    write_reg(REG_BIAS_K, 32'h0000_0000);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b1);
    settle();
    write_reg(REG_ALPHA, 32'h0000_0000);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0001, 1'b1);
    settle();
    write_reg(REG_BIAS_K, RST_BIAS_K);
    write_reg(REG_ALPHA, RST_ALPHA);
  endtask

  // window changes between items of one column, the sum wraps below zero
  task automatic test_resize_in_column();
    write_window(1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    settle();
    write_window(3);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    settle();
    write_window(9);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h0000, 1'b1);
    settle();
  endtask

  task automatic test_over_length();
    write_window(1);
    send_column(MAX_CHANNELS + 2);
    settle();
    write_window(4);
    send_column(MAX_CHANNELS + 1);
    settle();
    write_window(16);
    send_column(MAX_CHANNELS);
    settle();
  endtask

  task automatic test_output_backpressure();
    write_window(16);
    tx_idle_en = 1'b0;
    holds_asked++;
    send_column(40);
    tx_idle_en = 1'b1;
    settle();
  endtask

  task automatic test_random_columns(input int n_items);
    int sent, len;
    logic [CFG_DATA_W-1:0] data;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 2))
          0: write_window(($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                       : $urandom_range(1, 16));
          1: begin
            case ($urandom_range(0, 7))
              0: data = 32'h0000_0000;
              1: data = 32'hFFFF_FFFF;
              default: data = $urandom >> $urandom_range(0, 31);
            endcase
            write_reg(REG_BIAS_K, data);
          end
          default: begin
            data = $urandom;
            if ($urandom_range(0, 5) == 0) data[ALPHA_W-1:0] = '1;
            else data[ALPHA_W-1:0] = data[ALPHA_W-1:0] >> $urandom_range(0, 23);
            write_reg(REG_ALPHA, data);
          end
        endcase
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
      send_column(len);
      sent += len;
    end
    settle();
  endtask

  // output side: long hold on request, otherwise random stall bursts while rx_idle_en is set
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      m_ready      <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready    <= 1'b0;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_ready    <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_scales
    scale_item_t got, want;
    if (rst_n && m_valid && m_ready) begin
      got = {m_data[SCALE_W-1:0], m_data[SCALE_W +: IDX_W], m_last, m_user};
      if (due_scales.size() == 0) begin
        err_cnt++;
        if (err_cnt < 50)
          $display("%0t: unexpected item: expected none, got scale %h chan %0d done %b too_long %b",
                   $time, got.scale, got.chan, got.done, got.too_long);
      end else begin
        want = due_scales.pop_front();
        if (got !== want) begin
          err_cnt++;
          if (err_cnt < 50)
            $display("%0t: mismatch: expected scale %h chan %0d done %b too_long %b, got scale %h chan %0d done %b too_long %b",
                     $time, want.scale, want.chan, want.done, want.too_long,
                     got.scale, got.chan, got.done, got.too_long);
        end
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("lrn_cross_channel_scale_tb: errors");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_window_sizes();
    test_gain_extremes();
    test_resize_in_column();
    test_over_length();
    test_output_backpressure();
    test_random_columns(150);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_columns(50);
    if (err_cnt == 0) $display("lrn_cross_channel_scale_tb: clean");
    else $display("lrn_cross_channel_scale_tb: errors");
    $finish;
  end

endmodule
